### src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// types, codes and defaults shared by the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int NUM_PAGES_DEF  = 131072;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int WORD_BITS_DEF  = 64;

    localparam logic [63:0] PHYS_BASE_RST = 64'h0000_0000_4000_0000;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_IGNORED  = 3'd2,
        ST_OUTRAM   = 3'd3,
        ST_MISALIGN = 3'd4,
        ST_DOUBLE   = 3'd5,
        ST_BOUNDS   = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        CFG_PHYS_BASE = 1'b0,
        CFG_RESERVED  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] address;
        logic [17:0] run_length;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] base_address;
        logic [17:0] free_count;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INIT,
        S_SCAN_RD,
        S_SCAN,
        S_VER_RD,
        S_VER,
        S_MARK_RD,
        S_MARK,
        S_MARK_WR,
        S_BASE,
        S_DONE
    } state_t;

    // sequencer to page unit
    typedef struct packed {
        logic        set_mode;
        logic        clr_mode;
    } pu_ctrl_t;

endpackage

### src/bpa_map_ram.sv
// ----------------------------------------------------------------------------
// bpa_map_ram
// bitmap word store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bpa_map_ram
    import bpa_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int DEPTH     = 2048,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/bitmap_page_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// first-fit page allocator over a one-bit-per-page map held in block memory
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy low; its result appears for
// one cycle with done and cannot be held off by the receiver. The map lives
// in a memory of NUM_PAGES/WORD_BITS words with one read and one write port,
// and one sequencer walks it one page per cycle, pausing for a read at each
// new word and for the writes of the mark pass. An init clears the map word
// by word, then marks the bottom reserved_pages pages as taken. An allocate
// scans for the first run of free pages, reading each map word, then marks
// the run with a read and a write per word. A free verifies that every page
// of the run is taken, then clears the run with a read and a write per word.
// A command rejected at the first check goes to done without walking the map.
// After reset the map is cleared word by word, and busy stays high meanwhile.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int PW    = $clog2(NUM_PAGES + 1) + 1;
    localparam logic [PW-1:0] NP = PW'(NUM_PAGES);
    localparam logic [AW-1:0] LAST_W = AW'(WORDS - 1);

    state_t state_reg, state_next;
    logic [63:0] phys_base_reg;
    logic [17:0] reserved_reg;
    logic [17:0] free_reg, free_next;
    logic [1:0]  act_reg;
    logic [63:0] addr_reg;
    logic [17:0] len_reg;
    logic [PW-1:0] p_reg, p_next;       // walking page
    logic [PW-1:0] first_reg, first_next;
    logic [PW-1:0] last_reg, last_next;  // one past end of region
    logic [PW-1:0] run_reg, run_next;
    logic [AW-1:0] wclr_reg, wclr_next;
    logic          wipe_reg, wipe_next;
    logic [WORD_BITS-1:0] buf_reg, buf_next;
    logic [2:0]    st_reg, st_next;
    logic [63:0]   base_reg, base_next;
    logic          done_next;
    pu_ctrl_t      pu_reg, pu_next;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [WORD_BITS-1:0] wdata, rdata;
    logic [63:0]          offs;
    logic                 bit_now;
    logic [BW-1:0]        bsel;

    bpa_map_ram #(.WORD_BITS(WORD_BITS), .DEPTH(WORDS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign busy      = (state_reg != S_IDLE) || wipe_reg;
    assign cfg_ready = 1'b1;
    assign bsel      = p_reg[BW-1:0];
    assign bit_now   = rdata[bsel];
    assign offs      = addr_reg - phys_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phys_base_reg <= PHYS_BASE_RST;
            reserved_reg  <= '0;
            free_reg      <= 18'(NUM_PAGES);
            wipe_reg      <= 1'b1;
            wclr_reg      <= '0;
            done          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
            wipe_reg  <= wipe_next;
            wclr_reg  <= wclr_next;
            done      <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_PHYS_BASE: phys_base_reg <= cfg_data;
                    CFG_RESERVED:  reserved_reg  <= cfg_data[17:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            act_reg  <= cmd.action;
            addr_reg <= cmd.address;
            len_reg  <= cmd.run_length;
        end
        p_reg     <= p_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        run_reg   <= run_next;
        buf_reg   <= buf_next;
        st_reg    <= st_next;
        base_reg  <= base_next;
        pu_reg    <= pu_next;
    end

    assign result.status       = st_reg;
    assign result.base_address = base_reg;
    assign result.free_count   = free_reg;

    always_comb
    begin
        state_next = state_reg;
        free_next  = free_reg;
        wipe_next  = wipe_reg;
        wclr_next  = wclr_reg;
        p_next     = p_reg;
        first_next = first_reg;
        last_next  = last_reg;
        run_next   = run_reg;
        buf_next   = buf_reg;
        st_next    = st_reg;
        base_next  = base_reg;
        pu_next    = pu_reg;
        done_next  = 1'b0;
        we         = 1'b0;
        waddr      = wclr_reg;
        wdata      = '0;
        raddr      = p_reg[BW +: AW];

        if (wipe_reg)
        begin
            we = 1'b1;
            wclr_next = wclr_reg + AW'(1);
            if (wclr_reg == LAST_W)
            begin
                wclr_next = '0;
                wipe_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy)
                begin
                    state_next = S_CHECK;
                    base_next  = '0;
                end
            end
            S_CHECK:
            begin
                p_next    = '0;
                run_next  = '0;
                state_next = S_DONE;
                case (action_t'(act_reg))
                    ACT_INIT:
                    begin
                        st_next   = ST_OK;
                        wipe_next = 1'b1;
                        wclr_next = '0;
                        last_next = (reserved_reg > 18'(NUM_PAGES)) ? NP
                                                                   : PW'(reserved_reg);
                        state_next = S_INIT;
                    end
                    ACT_ALLOC:
                    begin
                        if (len_reg == '0)
                            st_next = ST_IGNORED;
                        else
                            state_next = S_SCAN_RD;
                    end
                    ACT_FREE:
                    begin
                        if (addr_reg == '0 || len_reg == '0)
                            st_next = ST_IGNORED;
                        else if (addr_reg < phys_base_reg
                                 || (offs >> PAGE_SHIFT) >= 64'(NUM_PAGES))
                            st_next = ST_OUTRAM;
                        else if (addr_reg[PAGE_SHIFT-1:0] != '0)
                            st_next = ST_MISALIGN;
                        else
                        begin
                            p_next     = PW'(offs >> PAGE_SHIFT);
                            first_next = PW'(offs >> PAGE_SHIFT);
                            last_next  = PW'(offs >> PAGE_SHIFT) + PW'(len_reg);
                            state_next = S_VER_RD;
                        end
                    end
                    default: st_next = ST_IGNORED;
                endcase
            end
            S_INIT:
            begin
                if (!wipe_reg)
                begin
                    free_next  = 18'(NP - last_reg);
                    pu_next    = '{set_mode: 1'b1, clr_mode: 1'b0};
                    p_next     = '0;
                    first_next = '0;
                    state_next = (last_reg == '0) ? S_DONE : S_MARK_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN;
                if (p_reg >= NP)
                begin
                    st_next    = ST_NOSPACE;
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                p_next = p_reg + PW'(1);
                if (bit_now)
                    run_next = '0;
                else
                begin
                    if (run_reg == '0)
                        first_next = p_reg;
                    run_next = run_reg + PW'(1);
                    if (run_reg + PW'(1) == PW'(len_reg))
                    begin
                        first_next = (run_reg == '0) ? p_reg : first_reg;
                        last_next  = p_reg + PW'(1);
                        p_next     = (run_reg == '0) ? p_reg : first_reg;
                        free_next  = (free_reg >= len_reg) ? free_reg - len_reg : '0;
                        pu_next    = '{set_mode: 1'b1, clr_mode: 1'b0};
                        state_next = S_MARK_RD;
                    end
                end
                if (state_next != S_MARK_RD)
                begin
                    if (p_reg + PW'(1) >= NP)
                    begin
                        st_next    = ST_NOSPACE;
                        state_next = S_DONE;
                    end
                    else if (p_next[BW-1:0] == '0)
                        state_next = S_SCAN_RD;
                end
            end
            S_VER_RD:
            begin
                state_next = S_VER;
                if (p_reg >= NP)
                begin
                    st_next    = ST_BOUNDS;
                    state_next = S_DONE;
                end
            end
            S_VER:
            begin
                p_next = p_reg + PW'(1);
                if (!bit_now)
                begin
                    st_next    = ST_DOUBLE;
                    state_next = S_DONE;
                end
                else if (p_reg + PW'(1) == last_reg)
                begin
                    p_next     = first_reg;
                    st_next    = ST_OK;
                    free_next  = (19'(free_reg) + 19'(len_reg) > 19'(NUM_PAGES))
                                 ? 18'(NUM_PAGES) : free_reg + len_reg;
                    pu_next    = '{set_mode: 1'b0, clr_mode: 1'b1};
                    state_next = S_MARK_RD;
                end
                else if (p_reg + PW'(1) >= NP)
                begin
                    st_next    = ST_BOUNDS;
                    state_next = S_DONE;
                end
                else if (p_next[BW-1:0] == '0)
                    state_next = S_VER_RD;
            end
            S_MARK_RD:
            begin
                state_next = S_MARK;
            end
            S_MARK:
            begin
                if (p_reg[BW-1:0] == '0 || p_reg == first_reg)
                    buf_next = rdata;
                buf_next[bsel] = pu_reg.set_mode;
                p_next = p_reg + PW'(1);
                if (p_reg + PW'(1) == last_reg || p_next[BW-1:0] == '0)
                    state_next = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                if (!wipe_reg)
                begin
                    we    = 1'b1;
                    waddr = p_reg[BW +: AW] - ((p_reg[BW-1:0] == '0) ? AW'(1) : AW'(0));
                    wdata = buf_reg;
                    if (p_reg == last_reg)
                        state_next = pu_reg.clr_mode ? S_DONE : S_BASE;
                    else
                        state_next = S_MARK_RD;
                end
            end
            S_BASE:
            begin
                st_next    = ST_OK;
                if (action_t'(act_reg) == ACT_ALLOC)
                    base_next = phys_base_reg + (64'(first_reg) << PAGE_SHIFT);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                pu_next    = '0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### src/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// port-level properties of the bitmap page allocator
// ----------------------------------------------------------------------------
module bpa_checker
    import bpa_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status <= ST_BOUNDS) else $error("bad status");

    a_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.base_address == '0)
        else $error("base on failure");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .result(result)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the first-fit bitmap page allocator
// ----------------------------------------------------------------------------
// Commands are queued by a generator, launched by a clocked driver with random
// gaps and predicted on acceptance against a local copy of the page map and
// free counter. A clocked monitor checks every done word against the oldest
// prediction. Directed cases cover the status codes, an oversized
// reservation filling the map and address wrap; random phases then mix allocations, proper
// frees of live runs, broken frees and noise under several page zero base and
// reserved_pages settings.
// ----------------------------------------------------------------------------
module tb_top;
    import bpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NP = NUM_PAGES_DEF;
    localparam int PS = PAGE_SHIFT_DEF;

    typedef struct {
        cmd_t c;
        int   gap;
    } pend_t;

    typedef struct {
        int pg;
        int len;
    } run_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [63:0] cfg_data;

    pend_t       pend_q[$];
    result_t     want_q[$];
    run_t        live_q[$];
    bit          pmap[NP];
    int          free_tot;
    logic [63:0] base_r;
    logic [17:0] resv_r;
    int          gap_cnt;
    int          errors;
    bit          no_gaps;
    int          big_left;

    bitmap_page_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string msg);
        $display("tb: mismatch %s", msg);
        errors++;
    endtask

    function automatic result_t step_alloc_map(input cmd_t c);
        result_t     r;
        int          cnt;
        int          run;
        int          st_pg;
        bit          found;
        logic [63:0] addr;
        logic [63:0] off;
        logic [63:0] first;
        logic [63:0] pg;
        r.status       = ST_OK;
        r.base_address = '0;
        cnt            = int'(c.run_length);
        addr           = c.address;
        case (action_t'(c.action))
            ACT_INIT:
            begin
                int n;
                n = (int'(resv_r) > NP) ? NP : int'(resv_r);
                for (int p = 0; p < NP; p++)
                    pmap[p] = (p < n);
                free_tot = NP - n;
                live_q.delete();
            end
            ACT_ALLOC:
            begin
                if (cnt == 0)
                    r.status = ST_IGNORED;
                else
                begin
                    run   = 0;
                    st_pg = 0;
                    found = 0;
                    for (int p = 0; p < NP && !found; p++)
                    begin
                        if (pmap[p])
                            run = 0;
                        else
                        begin
                            if (run == 0)
                                st_pg = p;
                            run++;
                            if (run == cnt)
                                found = 1;
                        end
                    end
                    if (!found)
                        r.status = ST_NOSPACE;
                    else
                    begin
                        for (int i = 0; i < cnt; i++)
                            pmap[st_pg + i] = 1;
                        free_tot = (free_tot >= cnt) ? free_tot - cnt : 0;
                        r.base_address = base_r + (64'(st_pg) << PS);
                        live_q.push_back('{st_pg, cnt});
                    end
                end
            end
            ACT_FREE:
            begin
                off   = addr - base_r;
                first = off >> PS;
                if (addr == 0 || cnt == 0)
                    r.status = ST_IGNORED;
                else if (addr < base_r || first >= 64'(NP))
                    r.status = ST_OUTRAM;
                else if ((addr & ((64'd1 << PS) - 1)) != 0)
                    r.status = ST_MISALIGN;
                else
                begin
                    for (int i = 0; i < cnt && r.status == ST_OK; i++)
                    begin
                        pg = first + 64'(i);
                        if (pg >= 64'(NP))
                            r.status = ST_BOUNDS;
                        else if (!pmap[int'(pg)])
                            r.status = ST_DOUBLE;
                    end
                    if (r.status == ST_OK)
                    begin
                        for (int i = 0; i < cnt; i++)
                            pmap[int'(first) + i] = 0;
                        free_tot += cnt;
                        if (free_tot > NP)
                            free_tot = NP;
                    end
                end
            end
            default:
                r.status = ST_IGNORED;
        endcase
        r.free_count = free_tot[17:0];
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            cmd     <= '0;
            gap_cnt <= 0;
        end
        else
        begin
            if (start && !busy)
                want_q.push_back(step_alloc_map(cmd));
            if (!start || !busy)
            begin
                if (pend_q.size() != 0 && gap_cnt >= pend_q[0].gap)
                begin
                    cmd     <= pend_q[0].c;
                    start   <= 1'b1;
                    gap_cnt <= 0;
                    pend_q.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                    if (pend_q.size() != 0)
                        gap_cnt <= gap_cnt + 1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (want_q.size() == 0)
                report("result word with nothing expected");
            else
            begin
                if (result.status !== want_q[0].status)
                    report($sformatf("status got %0d want %0d",
                        result.status, want_q[0].status));
                if (result.base_address !== want_q[0].base_address)
                    report($sformatf("base_address got %h want %h",
                        result.base_address, want_q[0].base_address));
                if (result.free_count !== want_q[0].free_count)
                    report($sformatf("free_count got %0d want %0d",
                        result.free_count, want_q[0].free_count));
                want_q.pop_front();
            end
        end
    end

    task automatic push_cmd(input action_t a, input logic [63:0] addr, input int len);
        pend_t e;
        e.c.action     = a;
        e.c.address    = addr;
        e.c.run_length = 18'(len);
        e.gap          = no_gaps ? 0 : $urandom_range(0, 13);
        pend_q.push_back(e);
        do
            @(negedge clk);
        while (pend_q.size() != 0 || start);
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || start || want_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [63:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        forever
        begin
            @(posedge clk);
            if (cfg_valid && cfg_ready)
                break;
        end
        cfg_valid <= 1'b0;
        if (idx == CFG_PHYS_BASE)
            base_r = v;
        else
            resv_r = v[17:0];
        @(negedge clk);
    endtask

    function automatic logic [63:0] pg_addr(input int pg);
        return base_r + (64'(pg) << PS);
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_item();
        int   k;
        int   idx;
        int   len;
        run_t r;
        k = $urandom_range(0, 99);
        if (big_left > 0 && $urandom_range(0, 59) == 0)
        begin
            big_left--;
            push_cmd(ACT_ALLOC, rnd64(), $urandom_range(0, 262143));
        end
        else if (k < 45 || (k < 85 && live_q.size() == 0))
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 200) : $urandom_range(1, 8);
            push_cmd(ACT_ALLOC, rnd64(), len);
        end
        else if (k < 75)
        begin
            idx = $urandom_range(0, live_q.size() - 1);
            r   = live_q[idx];
            live_q.delete(idx);
            push_cmd(ACT_FREE, pg_addr(r.pg), r.len);
        end
        else if (k < 85)
        begin
            idx = $urandom_range(0, live_q.size() - 1);
            r   = live_q[idx];
            live_q.delete(idx);
            case ($urandom_range(0, 3))
                0: push_cmd(ACT_FREE, pg_addr(r.pg), r.len + $urandom_range(1, 3));
                1: push_cmd(ACT_FREE, pg_addr(r.pg) + $urandom_range(1, 4095), r.len);
                2: push_cmd(ACT_FREE, pg_addr(r.pg - 1), r.len);
                default: push_cmd(ACT_FREE, pg_addr(r.pg), $urandom_range(1, r.len));
            endcase
        end
        else if (k < 95)
            push_cmd(ACT_FREE, rnd64(), $urandom_range(0, 262143));
        else if (k < 97)
            push_cmd(ACT_INIT, rnd64(), $urandom_range(0, 262143));
        else
            push_cmd(ACT_NONE, rnd64(), $urandom_range(0, 262143));
    endtask

    initial
    begin
        logic [63:0] bases[5];
        int          resvs[5];
        errors    = 0;
        no_gaps   = 0;
        big_left  = 2;
        base_r    = PHYS_BASE_RST;
        resv_r    = '0;
        free_tot  = NP;
        for (int p = 0; p < NP; p++)
            pmap[p] = 0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: status codes and edge addresses
        push_cmd(ACT_NONE, rnd64(), $urandom_range(0, 262143));
        push_cmd(ACT_INIT, rnd64(), $urandom_range(0, 262143));
        push_cmd(ACT_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        push_cmd(ACT_ALLOC, 64'h0, 1);
        push_cmd(ACT_ALLOC, rnd64(), 3);
        push_cmd(ACT_FREE, pg_addr(0), 1);
        push_cmd(ACT_FREE, pg_addr(0), 1);
        push_cmd(ACT_FREE, 64'h0, 5);
        push_cmd(ACT_FREE, pg_addr(1), 0);
        push_cmd(ACT_FREE, base_r - 64'd4096, 1);
        push_cmd(ACT_FREE, pg_addr(NP), 1);
        push_cmd(ACT_FREE, base_r + 64'd1, 1);
        push_cmd(ACT_FREE, pg_addr(NP - 1), 1);
        push_cmd(ACT_ALLOC, rnd64(), NP);
        drain();

        // oversized reservation fills the map
        cfg_write(CFG_RESERVED, 64'd262143);
        push_cmd(ACT_INIT, 64'h0, 0);
        push_cmd(ACT_FREE, pg_addr(NP - 1), 2);
        push_cmd(ACT_ALLOC, rnd64(), 1);
        push_cmd(ACT_FREE, pg_addr(NP - 1), 1);
        push_cmd(ACT_ALLOC, rnd64(), 1);
        drain();

        // zero base, null free, then wrapping base
        cfg_write(CFG_PHYS_BASE, 64'h0);
        cfg_write(CFG_RESERVED, 64'h0);
        push_cmd(ACT_INIT, 64'h0, 0);
        push_cmd(ACT_FREE, 64'h0, 1);
        push_cmd(ACT_ALLOC, rnd64(), 2);
        drain();
        cfg_write(CFG_PHYS_BASE, 64'hFFFF_FFFF_FFFF_F000);
        push_cmd(ACT_ALLOC, rnd64(), 1);
        push_cmd(ACT_FREE, pg_addr(2), 1);
        drain();

        bases[0] = PHYS_BASE_RST;
        resvs[0] = 0;
        bases[1] = rnd64() & ~64'hFFF;
        resvs[1] = $urandom_range(0, 2000);
        bases[2] = rnd64();
        resvs[2] = $urandom_range(0, 300);
        bases[3] = 64'h0;
        resvs[3] = 1;
        bases[4] = 64'hFFFF_FFFF_FFFF_FFFF;
        resvs[4] = 5;
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            cfg_write(CFG_PHYS_BASE, bases[ph]);
            cfg_write(CFG_RESERVED, 64'(resvs[ph]));
            push_cmd(ACT_INIT, rnd64(), $urandom_range(0, 262143));
            for (int n = 0; n < 52; n++)
            begin
                if ($urandom_range(0, 19) == 0)
                    no_gaps = !no_gaps;
                if ($urandom_range(0, 40) == 0)
                    drain();
                random_item();
            end
        end

        drain();
        repeat (64) @(posedge clk);
        if (errors == 0 && want_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #1_000_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
